@@ rtl/clns_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list neighbor search package
// Shared widths, command and register codes, and the configuration bundle.
// ----------------------------------------------------------------------------
package clns_pkg;

    localparam int ID_W       = 10;
    localparam int POS_W      = 32;
    localparam int RAD_W      = 24;
    localparam int HEAD_W     = ID_W + 1;
    localparam int PART_W     = 3 * POS_W + RAD_W;
    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAG_W      = 26;
    localparam int ACC_W      = 54;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_BOX_MIN_X   = 3'd0,
        REG_BOX_MIN_Y   = 3'd1,
        REG_BOX_MIN_Z   = 3'd2,
        REG_INV_CELL_X  = 3'd3,
        REG_INV_CELL_Y  = 3'd4,
        REG_INV_CELL_Z  = 3'd5,
        REG_SKIN_MARGIN = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] box_min;
        logic [2:0][POS_W-1:0] inv_cell;
        logic [RAD_W-1:0]      skin_margin;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/cell_list_neighbor_search_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list neighbor search
// Uniform 3-D linked cell grid: clear, load particle, query neighbors.
//
// Input beats carry a command in s_tuser (clear, load, query) and a particle
// id, position and radius in s_tdata. A load answers one beat with last set;
// it and a query carry an error status when the id is out of range or the
// cell falls outside the padded grid. A query answers one beat per neighbor
// within (r1 + r2 + margin), last and overflow (when neighbors were dropped)
// on the final beat, or one empty beat. A clear or a nop answers nothing.
// One item is in work at a time; s_tready is low until its last beat is
// placed in the output register. Loads and queries run through one shared
// 32x32 multiplier and single port reads; a query walks the 27 cells around
// its home cell, following each chain link and testing distances.
// A clear sweeps all GRID_X*GRID_Y*GRID_Z cell heads; the same
// sweep runs right after reset before the first beat is taken.
// When m_tready is low the result beat holds and the walk pauses at the next
// neighbor. Configuration writes are taken at any cycle with cfg_we high.
// ----------------------------------------------------------------------------
module cell_list_neighbor_search_top #(
    parameter int GRID_X        = 16,
    parameter int GRID_Y        = 16,
    parameter int GRID_Z        = 16,
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_NEIGHBORS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // particle_id, pos_x, pos_y, pos_z, radius, zero pad
    input  wire logic [clns_pkg::IN_DATA_W-1:0]     s_tdata,
    // command
    input  wire logic [clns_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // neighbor_id, zero pad
    output logic      [clns_pkg::OUT_DATA_W-1:0]    m_tdata,
    // found, overflow, status
    output logic      [clns_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [clns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [clns_pkg::CFG_DATA_W-1:0]    cfg_data
);

    clns_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_min     <= '0;
            cfg_reg.inv_cell    <= {3{32'd65536}};
            cfg_reg.skin_margin <= '0;
        end
        else if (cfg_we)
        begin
            case (clns_pkg::reg_idx_t'(cfg_index))
                clns_pkg::REG_BOX_MIN_X:   cfg_reg.box_min[0]  <= cfg_data;
                clns_pkg::REG_BOX_MIN_Y:   cfg_reg.box_min[1]  <= cfg_data;
                clns_pkg::REG_BOX_MIN_Z:   cfg_reg.box_min[2]  <= cfg_data;
                clns_pkg::REG_INV_CELL_X:  cfg_reg.inv_cell[0] <= cfg_data;
                clns_pkg::REG_INV_CELL_Y:  cfg_reg.inv_cell[1] <= cfg_data;
                clns_pkg::REG_INV_CELL_Z:  cfg_reg.inv_cell[2] <= cfg_data;
                clns_pkg::REG_SKIN_MARGIN: cfg_reg.skin_margin <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    clns_seq #(
        .GRID_X        (GRID_X),
        .GRID_Y        (GRID_Y),
        .GRID_Z        (GRID_Z),
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/clns_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module clns_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/clns_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiply with a registered 64 bit product.
// ----------------------------------------------------------------------------
module clns_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

@@ rtl/clns_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cell list sequencer
// Clears, loads and walks the cell grid, driving the shared multiplier
// and the cell, link and particle memories.
// ----------------------------------------------------------------------------
module clns_seq #(
    parameter int GRID_X        = 16,
    parameter int GRID_Y        = 16,
    parameter int GRID_Z        = 16,
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_NEIGHBORS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire clns_pkg::cfg_t                     cfg,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [clns_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic [clns_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [clns_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic      [clns_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic                                    m_tlast
);

    localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
    localparam int CAW        = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(GRID_X);
    localparam int YW         = $clog2(GRID_Y);
    localparam int ZW         = $clog2(GRID_Z);
    localparam int PD         = (MAX_PARTICLES < 1024) ? MAX_PARTICLES : 1024;
    localparam int PAW        = $clog2(PD);
    localparam int SW         = $clog2(MAX_PARTICLES + 1);
    localparam int NW         = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDW        = clns_pkg::ID_W;
    localparam int HW         = clns_pkg::HEAD_W;
    localparam int MW         = clns_pkg::MAG_W;
    localparam int AW         = clns_pkg::ACC_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_QRD, S_COORD, S_COORD_W, S_LHRD, S_LHW,
        S_CELL, S_CELL_W, S_CHAIN, S_NODE_W, S_DIST, S_DACC, S_THR,
        S_CMP, S_PUSH, S_NEXT, S_FINAL, S_EMIT
    } state_t;

    state_t                state_reg;
    logic [CAW-1:0]        clr_cnt_reg;
    clns_pkg::cmd_t        cmd_reg;
    logic [IDW-1:0]        id_reg;
    logic [2:0][31:0]      self_pos_reg;
    logic [23:0]           self_rad_reg;
    logic [1:0]            axis_reg;
    logic                  neg_reg;
    logic                  bad_reg;
    logic [XW-1:0]         cx_reg;
    logic [YW-1:0]         cy_reg;
    logic [ZW-1:0]         cz_reg;
    logic [1:0]            ox_reg;
    logic [1:0]            oy_reg;
    logic [1:0]            oz_reg;
    logic [HW-1:0]         cur_reg;
    logic [SW-1:0]         steps_reg;
    logic [AW-1:0]         acc_reg;
    logic [NW-1:0]         nb_cnt_reg;
    logic                  ovf_reg;
    logic                  pend_valid_reg;
    logic [IDW-1:0]        pend_id_reg;
    logic [IDW-1:0]        cand_id_reg;
    logic                  emit_status_reg;
    logic                  out_valid_reg;
    logic [IDW-1:0]        out_id_reg;
    logic                  out_found_reg;
    logic                  out_last_reg;
    logic                  out_ovf_reg;
    logic                  out_status_reg;

    logic                  accept;
    clns_pkg::cmd_t        in_cmd;
    logic [IDW-1:0]        in_id;
    logic                  in_id_ok;
    logic                  out_free;
    logic                  out_load;
    logic                  chain_go;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           mul_p;

    logic signed [32:0]    coord_diff;
    logic [32:0]           coord_mag;
    logic signed [33:0]    hi_s;
    logic signed [33:0]    coord;
    logic signed [33:0]    coord_lim;
    logic                  coord_ok;

    logic [2:0][31:0]      oth_pos;
    logic [23:0]           oth_rad;
    logic signed [32:0]    dist_diff;
    logic [32:0]           dist_mag;
    logic                  far;
    logic [MW-1:0]         rad_sum;

    logic [XW:0]           nx_w;
    logic [YW:0]           ny_w;
    logic [ZW:0]           nz_w;
    logic [CAW-1:0]        cidx;

    logic                  head_we;
    logic [CAW-1:0]        head_waddr;
    logic [HW-1:0]         head_wdata;
    logic                  head_re;
    logic [HW-1:0]         head_rdata;
    logic                  part_we;
    logic                  part_re;
    logic [PAW-1:0]        part_raddr;
    logic [clns_pkg::PART_W-1:0] part_rdata;
    logic                  link_we;
    logic                  link_re;
    logic [HW-1:0]         link_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_cmd   = clns_pkg::cmd_t'(s_tuser);
    assign in_id    = s_tdata[9:0];
    assign in_id_ok = 32'(in_id) < 32'(MAX_PARTICLES);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = out_free && (((state_reg == S_PUSH) && pend_valid_reg)
                                || (state_reg == S_FINAL) || (state_reg == S_EMIT));
    assign chain_go = cur_reg[HW-1] && (32'(steps_reg) < 32'(MAX_PARTICLES))
                   && (32'(cur_reg[IDW-1:0]) < 32'(MAX_PARTICLES));

    // cell coordinate from the shared product
    assign coord_diff = $signed({self_pos_reg[axis_reg][31], self_pos_reg[axis_reg]})
                      - $signed({cfg.box_min[axis_reg][31], cfg.box_min[axis_reg]});
    assign coord_mag  = coord_diff[32] ? 33'(-coord_diff) : 33'(coord_diff);
    assign hi_s       = $signed({2'b00, mul_p[63:32]});
    assign coord      = neg_reg ? (34'sd1 - hi_s - $signed({33'd0, |mul_p[31:0]}))
                                : (hi_s + 34'sd1);

    always_comb
    begin
        case (axis_reg)
            2'd0:    coord_lim = 34'(GRID_X - 2);
            2'd1:    coord_lim = 34'(GRID_Y - 2);
            default: coord_lim = 34'(GRID_Z - 2);
        endcase
    end

    assign coord_ok = (coord >= 34'sd1) && (coord <= coord_lim);

    // distance terms
    assign oth_pos   = part_rdata[95:0];
    assign oth_rad   = part_rdata[119:96];
    assign dist_diff = $signed({self_pos_reg[axis_reg][31], self_pos_reg[axis_reg]})
                     - $signed({oth_pos[axis_reg][31], oth_pos[axis_reg]});
    assign dist_mag  = dist_diff[32] ? 33'(-dist_diff) : 33'(dist_diff);
    assign far       = |dist_mag[32:MW];
    assign rad_sum   = MW'(self_rad_reg) + MW'(oth_rad) + MW'(cfg.skin_margin);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_COORD:
            begin
                mul_a = coord_mag[31:0];
                mul_b = cfg.inv_cell[axis_reg];
            end
            S_DIST:
            begin
                mul_a = 32'(dist_mag[MW-1:0]);
                mul_b = 32'(dist_mag[MW-1:0]);
            end
            S_THR:
            begin
                mul_a = 32'(rad_sum);
                mul_b = 32'(rad_sum);
            end
            default: ;
        endcase
    end

    // cell address around the home cell
    assign nx_w = (XW+1)'(cx_reg) + (XW+1)'(ox_reg) - (XW+1)'(1);
    assign ny_w = (YW+1)'(cy_reg) + (YW+1)'(oy_reg) - (YW+1)'(1);
    assign nz_w = (ZW+1)'(cz_reg) + (ZW+1)'(oz_reg) - (ZW+1)'(1);
    assign cidx = CAW'((int'(nz_w[ZW-1:0]) * GRID_Y + int'(ny_w[YW-1:0])) * GRID_X
                       + int'(nx_w[XW-1:0]));

    assign head_we    = (state_reg == S_CLEAR) || (state_reg == S_LHW);
    assign head_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : cidx;
    assign head_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, id_reg};
    assign head_re    = (state_reg == S_LHRD) || (state_reg == S_CELL);

    assign part_we    = accept && (in_cmd == clns_pkg::CMD_LOAD) && in_id_ok;
    assign part_re    = (accept && (in_cmd == clns_pkg::CMD_QUERY) && in_id_ok)
                     || ((state_reg == S_CHAIN) && chain_go);
    assign part_raddr = (state_reg == S_IDLE) ? in_id[PAW-1:0] : cur_reg[PAW-1:0];

    assign link_we    = (state_reg == S_LHW);
    assign link_re    = (state_reg == S_CHAIN) && chain_go;

    clns_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    clns_ram #(.WIDTH(HW), .DEPTH(CELL_COUNT)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (cidx),
        .rdata (head_rdata)
    );

    clns_ram #(.WIDTH(clns_pkg::PART_W), .DEPTH(PD)) u_part (
        .clk   (clk),
        .we    (part_we),
        .waddr (in_id[PAW-1:0]),
        .wdata (s_tdata[129:10]),
        .re    (part_re),
        .raddr (part_raddr),
        .rdata (part_rdata)
    );

    clns_ram #(.WIDTH(HW), .DEPTH(PD)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (id_reg[PAW-1:0]),
        .wdata (head_rdata),
        .re    (link_re),
        .raddr (cur_reg[PAW-1:0]),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            cmd_reg         <= clns_pkg::CMD_NOP;
            axis_reg        <= '0;
            bad_reg         <= 1'b0;
            ox_reg          <= '0;
            oy_reg          <= '0;
            oz_reg          <= '0;
            steps_reg       <= '0;
            nb_cnt_reg      <= '0;
            ovf_reg         <= 1'b0;
            pend_valid_reg  <= 1'b0;
            emit_status_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CAW'(1);
                    if (32'(clr_cnt_reg) == CELL_COUNT - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= in_cmd;
                        id_reg         <= in_id;
                        self_pos_reg   <= s_tdata[105:10];
                        self_rad_reg   <= s_tdata[129:106];
                        axis_reg       <= '0;
                        bad_reg        <= 1'b0;
                        ox_reg         <= 2'd1;
                        oy_reg         <= 2'd1;
                        oz_reg         <= 2'd1;
                        nb_cnt_reg     <= '0;
                        ovf_reg        <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        case (in_cmd)
                            clns_pkg::CMD_CLEAR:
                            begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            clns_pkg::CMD_LOAD:
                            begin
                                emit_status_reg <= 1'b1;
                                state_reg <= in_id_ok ? S_COORD : S_EMIT;
                            end
                            clns_pkg::CMD_QUERY:
                            begin
                                emit_status_reg <= 1'b1;
                                state_reg <= in_id_ok ? S_QRD : S_EMIT;
                            end
                            clns_pkg::CMD_NOP: ;
                            default: ;
                        endcase
                    end
                end
                S_QRD:
                begin
                    self_pos_reg <= part_rdata[95:0];
                    self_rad_reg <= part_rdata[119:96];
                    state_reg    <= S_COORD;
                end
                S_COORD:
                begin
                    neg_reg   <= coord_diff[32];
                    state_reg <= S_COORD_W;
                end
                S_COORD_W:
                begin
                    if (!coord_ok)
                    begin
                        bad_reg <= 1'b1;
                    end
                    case (axis_reg)
                        2'd0:    cx_reg <= coord[XW-1:0];
                        2'd1:    cy_reg <= coord[YW-1:0];
                        default: cz_reg <= coord[ZW-1:0];
                    endcase
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        if (bad_reg || !coord_ok)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else if (cmd_reg == clns_pkg::CMD_LOAD)
                        begin
                            state_reg <= S_LHRD;
                        end
                        else
                        begin
                            ox_reg    <= '0;
                            oy_reg    <= '0;
                            oz_reg    <= '0;
                            state_reg <= S_CELL;
                        end
                    end
                    else
                    begin
                        state_reg <= S_COORD;
                    end
                end
                S_LHRD:
                begin
                    state_reg <= S_LHW;
                end
                S_LHW:
                begin
                    emit_status_reg <= 1'b0;
                    state_reg       <= S_EMIT;
                end
                S_CELL:
                begin
                    state_reg <= S_CELL_W;
                end
                S_CELL_W:
                begin
                    cur_reg   <= head_rdata;
                    steps_reg <= '0;
                    state_reg <= S_CHAIN;
                end
                S_CHAIN:
                begin
                    state_reg <= chain_go ? S_NODE_W : S_NEXT;
                end
                S_NODE_W:
                begin
                    if (cur_reg[IDW-1:0] == id_reg)
                    begin
                        cur_reg   <= link_rdata;
                        steps_reg <= steps_reg + SW'(1);
                        state_reg <= S_CHAIN;
                    end
                    else
                    begin
                        axis_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    if (far)
                    begin
                        cur_reg   <= link_rdata;
                        steps_reg <= steps_reg + SW'(1);
                        state_reg <= S_CHAIN;
                    end
                    else
                    begin
                        state_reg <= S_DACC;
                    end
                end
                S_DACC:
                begin
                    acc_reg <= acc_reg + mul_p[AW-1:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_THR;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_DIST;
                    end
                end
                S_THR:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (acc_reg < mul_p[AW-1:0])
                    begin
                        if (32'(nb_cnt_reg) >= 32'(MAX_NEIGHBORS))
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_FINAL;
                        end
                        else
                        begin
                            cand_id_reg <= cur_reg[IDW-1:0];
                            state_reg   <= S_PUSH;
                        end
                    end
                    else
                    begin
                        cur_reg   <= link_rdata;
                        steps_reg <= steps_reg + SW'(1);
                        state_reg <= S_CHAIN;
                    end
                end
                S_PUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_id_reg     <= pend_id_reg;
                            out_found_reg  <= 1'b1;
                            out_last_reg   <= 1'b0;
                            out_ovf_reg    <= 1'b0;
                            out_status_reg <= 1'b0;
                        end
                        pend_id_reg    <= cand_id_reg;
                        pend_valid_reg <= 1'b1;
                        nb_cnt_reg     <= nb_cnt_reg + NW'(1);
                        cur_reg        <= link_rdata;
                        steps_reg      <= steps_reg + SW'(1);
                        state_reg      <= S_CHAIN;
                    end
                end
                S_NEXT:
                begin
                    state_reg <= S_CELL;
                    if (ox_reg != 2'd2)
                    begin
                        ox_reg <= ox_reg + 2'd1;
                    end
                    else
                    begin
                        ox_reg <= '0;
                        if (oy_reg != 2'd2)
                        begin
                            oy_reg <= oy_reg + 2'd1;
                        end
                        else
                        begin
                            oy_reg <= '0;
                            if (oz_reg != 2'd2)
                            begin
                                oz_reg <= oz_reg + 2'd1;
                            end
                            else
                            begin
                                state_reg <= S_FINAL;
                            end
                        end
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        out_id_reg     <= pend_valid_reg ? pend_id_reg : '0;
                        out_found_reg  <= pend_valid_reg;
                        out_last_reg   <= 1'b1;
                        out_ovf_reg    <= ovf_reg;
                        out_status_reg <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_id_reg     <= '0;
                        out_found_reg  <= 1'b0;
                        out_last_reg   <= 1'b1;
                        out_ovf_reg    <= 1'b0;
                        out_status_reg <= emit_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(clns_pkg::OUT_DATA_W - IDW)'(0), out_id_reg};
    assign m_tuser  = {out_status_reg, out_ovf_reg, out_found_reg};
    assign m_tlast  = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("pending neighbor left over at idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nb_cnt_reg) <= 32'(MAX_NEIGHBORS))
        else $error("neighbor count beyond limit");

    a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("overflow flag on a beat that is not last");

    a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (!m_tuser[0] && m_tlast))
        else $error("error status on a neighbor beat");

endmodule
`default_nettype wire

@@ sim/cell_list_neighbor_search_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell list neighbor search testbench
// Drives clear, load and query beats over the input stream while the test
// writes grid settings between phases. A built-in predictor of the cell
// grid checks every output beat. A directed table covers grid edges, errors
// and self loops. Random phases follow, with random gaps on both sides and
// one long output stall.
// ----------------------------------------------------------------------------
module cell_list_neighbor_search_top_test;

    localparam int GX = 16, GY = 16, GZ = 16, NPART = 1024, NMAX = 64;
    localparam int CELLS = GX * GY * GZ;
    localparam int UNIT = 65536;
    localparam int WATCH_LIMIT = 2000000;
    localparam int SETTLE = 5000;

    typedef struct packed {
        logic [clns_pkg::ID_W-1:0] nid;
        logic            found;
        logic            last;
        logic            ovf;
        logic            status;
    } beat_t;

    typedef struct {
        clns_pkg::cmd_t   cmd;
        logic [clns_pkg::ID_W-1:0]  id;
        logic [31:0]      x, y, z;
        logic [23:0]      r;
        bit               typed;
        bit               t_status;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [clns_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [clns_pkg::IN_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [clns_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [clns_pkg::OUT_USER_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 0;
    logic [clns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [clns_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    cell_list_neighbor_search_top #(
        .GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ),
        .MAX_PARTICLES(NPART), .MAX_NEIGHBORS(NMAX)
    ) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // grid state
    logic [clns_pkg::HEAD_W-1:0]   head_mem [CELLS];
    logic [clns_pkg::HEAD_W-1:0]   link_mem [NPART];
    longint              pos_mem  [NPART][3];
    longint unsigned     rad_mem  [NPART];
    longint              grid_min [3];
    longint unsigned     grid_inv [3];
    longint unsigned     margin;

    beat_t   expected_beats [$];
    int      loaded_ids [$];
    int      errors = 0;
    int      n_loads = 0, n_queries = 0, n_clears = 0, n_beats = 0, n_ovf = 0, n_bad = 0;
    int      idle_cycles = 0;
    bit      quiet = 0;
    bit      hold_req = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint cell_of(longint p, int axis);
        longint d;
        longint unsigned m, prod, q;
        d = p - grid_min[axis];
        m = (d < 0) ? longint'(-d) : d;
        prod = m * grid_inv[axis];
        if (d >= 0)
            return longint'(prod >> 32) + 1;
        q = (prod >> 32) + ((prod[31:0] != 0) ? 1 : 0);
        return 1 - longint'(q);
    endfunction

    function automatic bit locate_cell(int id, output int cx, output int cy, output int cz);
        longint x, y, z;
        x = cell_of(pos_mem[id][0], 0);
        y = cell_of(pos_mem[id][1], 1);
        z = cell_of(pos_mem[id][2], 2);
        cx = int'(x);
        cy = int'(y);
        cz = int'(z);
        return !(x < 1 || x > GX - 2 || y < 1 || y > GY - 2 || z < 1 || z > GZ - 2);
    endfunction

    function automatic bit within_reach(int a, int b);
        longint unsigned sum, acc, m;
        longint d;
        sum = rad_mem[a] + rad_mem[b] + margin;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = pos_mem[a][k] - pos_mem[b][k];
            m = (d < 0) ? longint'(-d) : d;
            if (m >= (64'd1 << clns_pkg::MAG_W))
                return 0;
            acc += m * m;
        end
        return acc < sum * sum;
    endfunction

    function automatic beat_t closing_beat(bit status);
        beat_t b;
        b = '0;
        b.last = 1;
        b.status = status;
        return b;
    endfunction

    // apply one accepted item to the grid and queue its answer beats
    function automatic void predict_item(clns_pkg::cmd_t cmd, int id, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z, logic [23:0] r,
                                         bit typed, bit t_status);
        beat_t ans [$];
        beat_t b;
        int cx, cy, cz, c, n, j;
        int unsigned steps;
        logic [clns_pkg::HEAD_W-1:0] cur;
        bit ovf;
        case (cmd)
            clns_pkg::CMD_CLEAR:
            begin
                foreach (head_mem[i])
                    head_mem[i] = '0;
                n_clears++;
            end
            clns_pkg::CMD_LOAD:
            begin
                n_loads++;
                pos_mem[id][0] = longint'($signed(x));
                pos_mem[id][1] = longint'($signed(y));
                pos_mem[id][2] = longint'($signed(z));
                rad_mem[id] = r;
                loaded_ids.push_back(id);
                if (!locate_cell(id, cx, cy, cz))
                    ans.push_back(closing_beat(1));
                else
                begin
                    c = (cz * GY + cy) * GX + cx;
                    link_mem[id] = head_mem[c];
                    head_mem[c] = {1'b1, id[clns_pkg::ID_W-1:0]};
                    ans.push_back(closing_beat(0));
                end
            end
            clns_pkg::CMD_QUERY:
            begin
                n_queries++;
                if (!locate_cell(id, cx, cy, cz))
                    ans.push_back(closing_beat(1));
                else
                begin
                    n = 0;
                    ovf = 0;
                    for (int dz = -1; dz <= 1 && !ovf; dz++)
                        for (int dy = -1; dy <= 1 && !ovf; dy++)
                            for (int dx = -1; dx <= 1 && !ovf; dx++)
                            begin
                                c = ((cz + dz) * GY + (cy + dy)) * GX + (cx + dx);
                                cur = head_mem[c];
                                steps = 0;
                                while (cur[clns_pkg::ID_W] && steps < NPART)
                                begin
                                    j = cur[clns_pkg::ID_W-1:0];
                                    if (j != id && within_reach(id, j))
                                    begin
                                        if (n >= NMAX)
                                        begin
                                            ovf = 1;
                                            break;
                                        end
                                        b = '0;
                                        b.nid = j;
                                        b.found = 1;
                                        ans.push_back(b);
                                        n++;
                                    end
                                    cur = link_mem[j];
                                    steps++;
                                end
                            end
                    if (n == 0)
                        ans.push_back(closing_beat(0));
                    else
                    begin
                        ans[n-1].last = 1;
                        ans[n-1].ovf = ovf;
                        if (ovf)
                            n_ovf++;
                    end
                end
            end
            default: ;
        endcase
        if (typed)
        begin
            ans.delete();
            ans.push_back(closing_beat(t_status));
        end
        foreach (ans[i])
            expected_beats.push_back(ans[i]);
    endfunction

    task automatic send_item(clns_pkg::cmd_t cmd, int id, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [23:0] r, bit typed, bit t_status);
        int g;
        g = quiet ? 0 : pick_gap();
        if (g > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, r, z, y, x, id[clns_pkg::ID_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(cmd, id, x, y, z, r, typed, t_status);
    endtask

    task automatic write_reg(clns_pkg::reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            clns_pkg::REG_BOX_MIN_X, clns_pkg::REG_BOX_MIN_Y, clns_pkg::REG_BOX_MIN_Z:
                grid_min[idx] = longint'($signed(val));
            clns_pkg::REG_INV_CELL_X, clns_pkg::REG_INV_CELL_Y, clns_pkg::REG_INV_CELL_Z:
                grid_inv[idx - clns_pkg::REG_INV_CELL_X] = val;
            default:
                margin = val[clns_pkg::RAD_W-1:0];
        endcase
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_grid(logic [31:0] mn, logic [31:0] inv, logic [31:0] mg);
        write_reg(clns_pkg::REG_BOX_MIN_X, mn);
        write_reg(clns_pkg::REG_BOX_MIN_Y, mn + 32'd7);
        write_reg(clns_pkg::REG_BOX_MIN_Z, mn - 32'd3);
        write_reg(clns_pkg::REG_INV_CELL_X, inv);
        write_reg(clns_pkg::REG_INV_CELL_Y, inv);
        write_reg(clns_pkg::REG_INV_CELL_Z, inv);
        write_reg(clns_pkg::REG_SKIN_MARGIN, mg);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly clustered loads and queries of loaded particles, some noise
    task automatic random_phase(int count, logic [31:0] lo, int unsigned span,
                                int unsigned rmax);
        int k, sel, id;
        logic [31:0] p [3];
        logic [23:0] r;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            id = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NPART - 1)
                                             : $urandom_range(0, 31);
            for (int a = 0; a < 3; a++)
                p[a] = ($urandom_range(0, 4) == 0) ? $urandom : lo + $urandom_range(0, span);
            r = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, rmax));
            if (sel < 6)
                send_item(clns_pkg::CMD_CLEAR, $urandom_range(0, NPART - 1), $urandom,
                          $urandom, $urandom, 24'($urandom), 0, 0);
            else if (sel < 9)
                send_item(clns_pkg::CMD_NOP, id, $urandom, $urandom, $urandom,
                          24'($urandom), 0, 0);
            else if (sel < 55 || loaded_ids.size() == 0)
                send_item(clns_pkg::CMD_LOAD, id, p[0], p[1], p[2], r, 0, 0);
            else
                send_item(clns_pkg::CMD_QUERY,
                          loaded_ids[$urandom_range(0, loaded_ids.size() - 1)],
                          $urandom, $urandom, $urandom, 24'($urandom), 0, 0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            beat_t e;
            n_beats++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat id=%0d user=%b last=%b",
                         $time, m_tdata[clns_pkg::ID_W-1:0], m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                e = expected_beats.pop_front();
                if (m_tdata[clns_pkg::ID_W-1:0] !== e.nid)
                begin
                    $display("%0t: neighbor_id expected %0d got %0d", $time, e.nid,
                             m_tdata[clns_pkg::ID_W-1:0]);
                    errors++;
                end
                if (m_tuser[0] !== e.found)
                begin
                    $display("%0t: found expected %b got %b", $time, e.found, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.ovf)
                begin
                    $display("%0t: overflow expected %b got %b", $time, e.ovf, m_tuser[1]);
                    errors++;
                end
                if (m_tuser[2] !== e.status)
                begin
                    $display("%0t: status expected %b got %b", $time, e.status, m_tuser[2]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $display("%0t: last expected %b got %b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d beats outstanding", $time,
                     expected_beats.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                g = pick_gap();
                m_tready <= 1'b0;
                repeat ((g < 1) ? 1 : g) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        row_t rows [$];
        row_t rw;
        foreach (head_mem[i])
            head_mem[i] = '0;
        foreach (link_mem[i])
            link_mem[i] = '0;
        foreach (rad_mem[i])
        begin
            rad_mem[i] = 0;
            pos_mem[i][0] = 0;
            pos_mem[i][1] = 0;
            pos_mem[i][2] = 0;
        end
        for (int a = 0; a < 3; a++)
        begin
            grid_min[a] = 0;
            grid_inv[a] = UNIT;
        end
        margin = 0;

        rows.push_back('{clns_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 0, 3*UNIT/2, 3*UNIT/2, 3*UNIT/2, UNIT/2, 1, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 1023, 19*UNIT/10, 3*UNIT/2, 3*UNIT/2,
                         24'hFFFFFF, 1, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 2, 32'h7FFFFFFF, 3*UNIT/2, 3*UNIT/2, 0, 1, 1});
        rows.push_back('{clns_pkg::CMD_LOAD, 3, 32'h80000000, 3*UNIT/2, 3*UNIT/2, UNIT, 1, 1});
        rows.push_back('{clns_pkg::CMD_LOAD, 4, 3*UNIT/2, 32'hFFFFFFFF, 3*UNIT/2, UNIT, 1, 1});
        rows.push_back('{clns_pkg::CMD_LOAD, 5, 3*UNIT/2, 3*UNIT/2, 14*UNIT, UNIT, 1, 1});
        rows.push_back('{clns_pkg::CMD_LOAD, 6, 14*UNIT-1, 14*UNIT-1, 14*UNIT-1, UNIT, 1, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 7, 22*UNIT/10, 3*UNIT/2, 3*UNIT/2, UNIT/5, 1, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 1023, 0, 0, 0, 0, 0, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 3, 0, 0, 0, 0, 1, 1});
        rows.push_back('{clns_pkg::CMD_NOP, 1023, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                         24'hFFFFFF, 0, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 6, 0, 0, 0, 0, 1, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 0, 3*UNIT/2, 3*UNIT/2, 3*UNIT/2, UNIT/2, 1, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 1023, 0, 0, 0, 0, 0, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 7, 0, 0, 0, 0, 0, 0});
        rows.push_back('{clns_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 1, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 512, 3*UNIT/2, 3*UNIT/2, 3*UNIT/2, 0, 1, 0});
        rows.push_back('{clns_pkg::CMD_LOAD, 8, 3*UNIT/2, 3*UNIT/2, 3*UNIT/2, 0, 1, 0});
        rows.push_back('{clns_pkg::CMD_QUERY, 8, 0, 0, 0, 0, 0, 0});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            rw = rows[i];
            send_item(rw.cmd, rw.id, rw.x, rw.y, rw.z, rw.r, rw.typed, rw.t_status);
        end

        hold_req = 1;
        random_phase(20, 2*UNIT, 3*UNIT, 4*UNIT/5);
        settle();

        set_grid(-32'sd344064, 2*UNIT, UNIT/4);
        quiet = 1;
        send_item(clns_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        random_phase(12, -32'sd300000, 2*UNIT, 2*UNIT/5);
        quiet = 0;
        random_phase(18, -32'sd300000, 2*UNIT, 2*UNIT/5);
        settle();

        set_grid(32'h80000000, 32'd0, 32'hFFFFFF);
        send_item(clns_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        random_phase(20, 32'd0, 1 << 25, 24'hFFFFFF);
        settle();

        set_grid(32'h7FFFFFFF, 32'hFFFFFFFF, 32'd0);
        send_item(clns_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        random_phase(20, 32'h7FFFFFF0, 15, UNIT);
        settle();

        set_grid(32'd0, UNIT, UNIT/8);
        send_item(clns_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        random_phase(20, 2*UNIT, 3*UNIT, 4*UNIT/5);

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (500) @(posedge clk);

        $display("Covered %0d loads, %0d queries, %0d clears over 5 grid settings;",
                 n_loads, n_queries, n_clears);
        $display("checked %0d result beats, %0d queries hit the neighbor cap.", n_beats, n_ovf);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/clns_pkg.sv
rtl/clns_ram.sv
rtl/clns_mul.sv
rtl/clns_seq.sv
rtl/cell_list_neighbor_search_top.sv
sim/cell_list_neighbor_search_top_test.sv
